FILE: sv/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types and constants for the interpolation search table.
// ----------------------------------------------------------------------------
`default_nettype none

package ist_pkg;

    localparam int DATA_W = 32;              // table word and key width
    localparam int IDX_W  = 7;               // width of bounds and positions
    localparam int QUOT_W = IDX_W;           // probe offset never exceeds high - low
    localparam int PROD_W = DATA_W + IDX_W;  // (key - t[low]) * (high - low)

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] value;
        logic        [IDX_W-1:0]  low_bound;
        logic        [IDX_W-1:0]  high_bound;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] position;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: sv/ist_ram.sv
// ----------------------------------------------------------------------------
// ist_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/ist_div.sv
// ----------------------------------------------------------------------------
// ist_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QUOT_W bits, so only that many steps are run.
// ----------------------------------------------------------------------------
`default_nettype none

module ist_div
    import ist_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(QUOT_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [QUOT_W-1:0] bits_reg;   // dividend bits shift out, quotient bits shift in
    logic [DATA_W-1:0] dsr_reg;

    logic [DATA_W:0]   trial;
    logic              take;
    logic [DATA_W-1:0] rem_next;

    assign trial    = {rem_reg, bits_reg[QUOT_W-1]};
    assign take     = trial >= {1'b0, dsr_reg};
    assign rem_next = take ? DATA_W'(trial - {1'b0, dsr_reg}) : trial[DATA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.dividend[PROD_W-1:QUOT_W];
            bits_reg <= req.dividend[QUOT_W-1:0];
            dsr_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            bits_reg <= {bits_reg[QUOT_W-2:0], take};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = bits_reg;

endmodule

`default_nettype wire

FILE: sv/interpolation_search_table.sv
// ----------------------------------------------------------------------------
// interpolation_search_table
// Ascending table of signed words with append and interpolation search.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload      Transfer carries
//  -------   ------------------   ----------   ---------------------------------
//  input     in_valid/in_ready    in_data      append value, or search key+bounds
//  output    out_valid/out_ready  out_data     found flag and position (searches)
//
// An append produces no output transfer. A search runs one or more probes;
// each probe takes two table reads for the ends of the range, a 32x7
// multiply, a 7-step divider and one read of the probed entry, and every
// table read goes through the single read port of the table RAM. A probe
// may stop at the range check. The answer passes from the result state to
// the output register; bad bounds go from the accepted transfer straight to
// the result state.
// Reset clears the fill count and the control state; the table contents are
// not cleared, since only filled entries are ever read.
// The block takes a new input while a result waits in the output register;
// a finished search stalls only when that register is still occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module interpolation_search_table
    import ist_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RLO  = 4'd1;  // read t[low]
    localparam logic [3:0] S_RHI  = 4'd2;  // read t[high], capture t[low]
    localparam logic [3:0] S_CHK  = 4'd3;  // range check, set up the interpolation
    localparam logic [3:0] S_MUL  = 4'd4;  // numerator product
    localparam logic [3:0] S_DIVS = 4'd5;  // start the divider
    localparam logic [3:0] S_DIV  = 4'd6;  // wait for the quotient
    localparam logic [3:0] S_RPR  = 4'd7;  // read t[probe]
    localparam logic [3:0] S_CMP  = 4'd8;  // compare and narrow
    localparam logic [3:0] S_RES  = 4'd9;  // hand the result to the output register

    logic [3:0]               state_reg, state_next;
    logic [CW-1:0]            fill_reg;
    logic                     out_valid_reg;
    out_item_t                out_data_reg;

    // Search payload registers.
    logic signed [DATA_W-1:0] key_reg;
    logic [IDX_W-1:0]         lo_reg;
    logic [IDX_W-1:0]         hi_reg;
    logic [IDX_W-1:0]         probe_reg;
    logic signed [DATA_W-1:0] tl_reg;
    logic [DATA_W-1:0]        num_reg;
    logic [DATA_W-1:0]        den_reg;
    logic [IDX_W-1:0]         span_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     res_found_reg;
    logic [IDX_W-1:0]         res_pos_reg;

    // Table RAM ports.
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [AW-1:0]            ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;
    logic signed [DATA_W-1:0] rd_word;

    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    logic                     in_fire;
    logic                     full;
    logic                     bounds_bad;
    logic                     out_free;
    logic signed [DATA_W:0]   num_wide;
    logic signed [DATA_W:0]   den_wide;

    assign in_fire    = in_valid && in_ready;
    assign full       = (fill_reg == CW'(DEPTH));
    assign bounds_bad = (in_data.low_bound > in_data.high_bound) ||
                        (32'(in_data.high_bound) >= 32'(fill_reg));
    assign out_free   = !out_valid_reg || out_ready;
    assign rd_word    = $signed(ram_rdata);

    // Both differences are non-negative once the key lies inside the range.
    assign num_wide = {key_reg[DATA_W-1], key_reg} - {tl_reg[DATA_W-1], tl_reg};
    assign den_wide = {rd_word[DATA_W-1], rd_word} - {tl_reg[DATA_W-1], tl_reg};

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Appends write at the fill position; searches read one entry at a time.
    assign ram_we    = in_fire && (in_data.op == OP_APPEND) && !full;
    assign ram_waddr = AW'(fill_reg);

    always_comb
    begin
        unique case (state_reg)
            S_RHI:   ram_raddr = AW'(hi_reg);
            S_RPR:   ram_raddr = AW'(probe_reg);
            default: ram_raddr = AW'(lo_reg);
        endcase
    end

    ist_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_data.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign div_req.start    = (state_reg == S_DIVS);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = den_reg;

    ist_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (in_data.op == OP_SEARCH))
                begin
                    state_next = bounds_bad ? S_RES : S_RLO;
                end
            end
            S_RLO:  state_next = S_RHI;
            S_RHI:  state_next = S_CHK;
            S_CHK:
            begin
                if ((key_reg < tl_reg) || (key_reg > rd_word) || (rd_word == tl_reg))
                begin
                    state_next = S_RES;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:  state_next = S_DIVS;
            S_DIVS: state_next = S_DIV;
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_RPR;
                end
            end
            S_RPR:  state_next = S_CMP;
            S_CMP:
            begin
                // A hit ends the search, and so does a probe at the edge of the
                // range on the side that the search would move past.
                if ((rd_word == key_reg) ||
                    ((rd_word < key_reg) && (probe_reg == hi_reg)) ||
                    ((rd_word > key_reg) && (probe_reg == lo_reg)))
                begin
                    state_next = S_RES;
                end
                else
                begin
                    state_next = S_RLO;
                end
            end
            S_RES:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                fill_reg <= fill_reg + CW'(1);
            end
            if ((state_reg == S_RES) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Search payload registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                key_reg       <= in_data.value;
                lo_reg        <= in_data.low_bound;
                hi_reg        <= in_data.high_bound;
                res_found_reg <= 1'b0;
                res_pos_reg   <= '0;
            end
            S_RHI:
            begin
                tl_reg <= rd_word;
            end
            S_CHK:
            begin
                // With equal ends the key is inside the range only if it matches.
                if ((rd_word == tl_reg) && (key_reg == tl_reg))
                begin
                    res_found_reg <= 1'b1;
                    res_pos_reg   <= lo_reg;
                end
                num_reg  <= num_wide[DATA_W-1:0];
                den_reg  <= den_wide[DATA_W-1:0];
                span_reg <= hi_reg - lo_reg;
            end
            S_MUL:
            begin
                prod_reg <= PROD_W'(num_reg) * PROD_W'(span_reg);
            end
            S_DIV:
            begin
                probe_reg <= lo_reg + div_rsp.quotient;
            end
            S_CMP:
            begin
                if (rd_word == key_reg)
                begin
                    res_found_reg <= 1'b1;
                    res_pos_reg   <= probe_reg;
                end
                else if (rd_word < key_reg)
                begin
                    lo_reg <= probe_reg + IDX_W'(1);
                end
                else
                begin
                    hi_reg <= probe_reg - IDX_W'(1);
                end
            end
            S_RES:
            begin
                if (out_free)
                begin
                    out_data_reg.found    <= res_found_reg;
                    out_data_reg.position <= res_pos_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // The fill count never runs past the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= DEPTH)
        else $error("fill count exceeds table depth");

    // An accepted append on a table that is not full grows the fill by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_data.op == OP_APPEND) && !full)
        |=> (fill_reg == $past(fill_reg) + CW'(1)))
        else $error("append did not advance the fill count");

    // The divider only reports a quotient while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside its wait state");

    // Every probe lies inside the current range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RPR) |-> ((probe_reg >= lo_reg) && (probe_reg <= hi_reg)))
        else $error("probe outside the search range");
`endif

endmodule

`default_nettype wire
